// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Field widths, action codes and the result bundle handed from the
// sequencer to the output stage.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int ACT_W        = 3;
	localparam int POS_W        = 6;
	localparam int DATA_W       = 32;
	localparam int LEN_W        = 6;
	localparam int CAPACITY_DEF = 32;

	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

	typedef struct packed {
		logic              valid;
		logic              status;
		logic [DATA_W-1:0] elem;
		logic [LEN_W-1:0]  found;
		logic [LEN_W-1:0]  length;
		logic              empty;
	} pal_res_t;

endpackage

// ===== rtl/positional_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_unit: ordered list of signed 32-bit entries
// Insert, delete, find, get and clear by 1-based position, one result per
// request, with a registered output stage.
// ----------------------------------------------------------------------------
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+------------------------------------------
//  request  | in_valid  | in_stall  | action, position, value
//  result   | out_valid | out_stall | status, element_value, found_position,
//           |           |           | list_length, is_empty
//
//  One request at a time; the store is walked one entry per cycle through
//  its single read port. Insert shifts the entries from pos onward up,
//  delete shifts the entries after pos down, find scans up to count entries,
//  get reads one entry, and clear and rejected requests go straight to the
//  result. The next request is taken once the sequencer is idle again,
//  after its result has moved into the output register.
//  Reset clears the entry count and the sequencer state; the store needs no clearing pass.
//  A waiting result sits in the output register while the next request is
//  taken; out_stall holds the sequencer in its done state.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pal_pkg::ACT_W-1:0]  action,
	input  logic [pal_pkg::POS_W-1:0]  position,
	input  logic [pal_pkg::DATA_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [pal_pkg::DATA_W-1:0] element_value,
	output logic [pal_pkg::LEN_W-1:0]  found_position,
	output logic [pal_pkg::LEN_W-1:0]  list_length,
	output logic                       is_empty
);
	import pal_pkg::*;

	pal_res_t res;
	logic     busy;
	logic     start;
	logic     take;
	logic     out_valid_q;

	assign start = in_valid && !busy;
	assign take  = !out_valid_q || !out_stall;

	pal_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.action   (action),
		.position (position),
		.value    (value),
		.res_take (take),
		.busy     (busy),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			status         <= res.status;
			element_value  <= res.elem;
			found_position <= res.found;
			list_length    <= res.length;
			is_empty       <= res.empty;
		end
	end

	assign in_stall  = busy;
	assign out_valid = out_valid_q;

	// a transfer in always leaves the sequencer busy, so the next cycle is stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request port not stalled after a transfer");

	a_error_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (element_value == '0) && (found_position == '0))
		else $error("failed request carries a value or position");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (found_position != '0) |-> !status && (element_value == '0))
		else $error("find hit with error or element value");

endmodule

// ===== rtl/pal_ram.sv =====
// ----------------------------------------------------------------------------
// pal_ram: entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pal_ram #(
	parameter int DEPTH = pal_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(pal_pkg::CAPACITY_DEF),
	parameter int DW    = pal_pkg::DATA_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl: list sequencer
// Walks the entry store one entry per cycle with a shared pointer stepper
// and bound compare: shifts up for insert, down for delete, scans for find.
// ----------------------------------------------------------------------------
module pal_ctrl #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pal_pkg::ACT_W-1:0]    action,
	input  logic [pal_pkg::POS_W-1:0]    position,
	input  logic [pal_pkg::DATA_W-1:0]   value,
	input  logic                         res_take,
	output logic                         busy,
	output pal_pkg::pal_res_t            res
);
	import pal_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP    = 3'd1;
	localparam logic [2:0] S_DN    = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_CAP   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     lim_q;
	logic [CW-1:0]     rd_idx_q;
	logic              rd_pend_q;
	logic              del_q;
	logic [DATA_W-1:0] val_q;
	logic              status_q;
	logic [DATA_W-1:0] elem_q;
	logic [CW-1:0]     found_q;

	logic [CMP_W-1:0]  pos_e;
	logic [CMP_W-1:0]  cnt_e;
	logic [CW-1:0]     pos_m1;
	logic              ins_err;
	logic              rd_err;
	logic              dir_dn;
	logic              more;
	logic [CW-1:0]     step;
	logic [CW-1:0]     rd_idx_w;
	logic [CW-1:0]     rd_adj;
	logic              hit;
	logic              issue;
	logic              re;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rd_data;

	pal_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign pos_e   = CMP_W'(position);
	assign cnt_e   = CMP_W'(count_q);
	assign pos_m1  = CW'(pos_e - CMP_W'(1));
	assign ins_err = (cnt_e >= CMP_W'(CAPACITY)) || (pos_e == '0) ||
	                 ((pos_e - CMP_W'(1)) > cnt_e);
	assign rd_err  = (cnt_e == '0) || (pos_e == '0) || (pos_e > cnt_e);

	// shared pointer unit: step toward the bound, one entry per cycle
	assign dir_dn   = (state_q == S_UP);
	assign more     = (ptr_q != lim_q);
	assign step     = dir_dn ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));
	assign rd_idx_w = dir_dn ? step : ptr_q;
	// write-back target for shifts, 1-based position for find
	assign rd_adj   = (state_q == S_DN) ? (rd_idx_q - CW'(1)) : (rd_idx_q + CW'(1));
	assign hit      = rd_pend_q && (rd_data == val_q);

	always_comb begin
		issue = 1'b0;
		we    = 1'b0;
		waddr = rd_adj[AW-1:0];
		wdata = rd_data;
		case (state_q)
			S_UP: begin
				we = rd_pend_q;
				if (more) begin
					issue = 1'b1;
				end else if (!rd_pend_q) begin
					we    = 1'b1;
					waddr = lim_q[AW-1:0];
					wdata = val_q;
				end
			end
			S_DN: begin
				we    = rd_pend_q;
				issue = more;
			end
			S_SCAN: begin
				issue = more && !hit;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
		re    = issue || (state_q == S_FETCH);
		raddr = rd_idx_w[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (action)
							ACT_INSERT: state_q <= ins_err ? S_DONE : S_UP;
							ACT_DELETE: state_q <= rd_err ? S_DONE : S_FETCH;
							ACT_GET:    state_q <= rd_err ? S_DONE : S_FETCH;
							ACT_FIND:   state_q <= S_SCAN;
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_UP: begin
					if (!more && !rd_pend_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DN: begin
					if (!more) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (hit || !more) begin
						state_q <= S_DONE;
					end
				end
				S_FETCH: state_q <= S_CAP;
				S_CAP:   state_q <= del_q ? S_DN : S_DONE;
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_q <= rd_idx_w;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					val_q    <= value;
					del_q    <= (action == ACT_DELETE);
					elem_q   <= '0;
					found_q  <= '0;
					status_q <= 1'b0;
					case (action)
						ACT_INSERT: begin
							status_q <= ins_err;
							ptr_q    <= count_q;
							lim_q    <= pos_m1;
						end
						ACT_DELETE, ACT_GET: begin
							status_q <= rd_err;
							ptr_q    <= pos_m1;
							lim_q    <= count_q;
						end
						ACT_FIND: begin
							ptr_q <= '0;
							lim_q <= count_q;
						end
						ACT_CLEAR: status_q <= 1'b0;
						default:   status_q <= 1'b1;
					endcase
				end
			end
			S_UP, S_DN: begin
				if (more) begin
					ptr_q <= step;
				end
			end
			S_SCAN: begin
				if (hit) begin
					found_q <= rd_adj;
				end else if (more) begin
					ptr_q <= step;
				end
			end
			S_FETCH: ptr_q <= step;
			S_CAP:   elem_q <= rd_data;
			default: ptr_q <= ptr_q;
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign res.valid  = (state_q == S_DONE);
	assign res.status = status_q;
	assign res.elem   = elem_q;
	assign res.found  = LEN_W'(found_q);
	assign res.length = LEN_W'(count_q);
	assign res.empty  = (count_q == '0);

endmodule
